// ----- design/bsc_pkg.sv -----
// Shared types and constants for the binary sequence cross-correlator
package bsc_pkg;

    // fixed field and register widths
    localparam int PAT_W   = 64;
    localparam int LEN_W   = 7;
    localparam int AGE_W   = 6;
    localparam int LAG_W   = 16;
    localparam int SCORE_W = 8;
    localparam int DATA_W  = 64;
    localparam int ADDR_W  = 4;

    // reset value of the length register
    localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;

    // register select codes, taken from paddr[3]
    localparam logic REG_PATTERN = 1'b0;
    localparam logic REG_LENGTH  = 1'b1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

endpackage

// ----- design/binary_sequence_cross_correlator.sv -----
// An item that completes a full window gives one score. An item marked last gives one
// score per open lag, each built over its overlap with one xor/count step per cycle; a
// finished score waits while the output register is busy. A new item is taken only
// while the sequencer is idle, so an item that gives scores holds off input until its
// last score is handed on. Reset clears history, count, pattern, sequencer; length to LEN_RESET.
module binary_sequence_cross_correlator #(
    parameter int REF_MAX    = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input items
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_data_bit,
    input  logic                        s_last,
    // result items
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [bsc_pkg::LAG_W-1:0]   m_lag,
    output logic signed [bsc_pkg::SCORE_W-1:0] m_score,
    output logic                        m_last_result,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bsc_pkg::ADDR_W-1:0]  paddr,
    input  logic [bsc_pkg::DATA_W-1:0]  pwdata,
    output logic [bsc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import bsc_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS:0]   LAG_MAX = (COUNT_BITS > LAG_W) ?
        (COUNT_BITS+1)'(65535) : {1'b0, CNT_MAX};

    // registers
    state_t                  state_reg, state_next;
    logic [PAT_W-1:0]        pattern_reg, pattern_next;
    logic [LEN_W-1:0]        length_reg, length_next;
    logic [PAT_W-1:0]        recent_reg, recent_next;
    logic [COUNT_BITS-1:0]   bits_seen_reg, bits_seen_next;
    logic [LEN_W-1:0]        w_reg, w_next;
    logic [LEN_W-1:0]        cnt_reg, cnt_next;
    logic [LEN_W-1:0]        i_reg, i_next;
    logic [LEN_W-1:0]        f_reg, f_next;
    logic [AGE_W-1:0]        age_reg, age_next;
    logic [LEN_W-1:0]        mism_reg, mism_next;
    logic                    last_reg, last_next;
    logic [COUNT_BITS-1:0]   start_reg, start_next;
    logic                    m_valid_reg, m_valid_next;
    logic [LAG_W-1:0]        m_lag_reg, m_lag_next;
    logic [SCORE_W-1:0]      m_score_reg, m_score_next;
    logic                    m_last_reg, m_last_next;

    // combinational helpers
    logic                    cfg_wr;
    logic                    s_fire;
    logic                    out_free;
    logic [LEN_W-1:0]        m_used;
    logic [COUNT_BITS-1:0]   c_new;
    logic [LEN_W-1:0]        w_new;
    logic                    full_win;
    logic [LEN_W-1:0]        n_cur;
    logic                    bit_mism;
    logic [LEN_W-1:0]        mism_inc;
    logic                    step_done;
    logic                    last_score;
    logic [COUNT_BITS:0]     lag_sum;
    logic [COUNT_BITS:0]     lag_sat;
    logic [SCORE_W-1:0]      score_val;
    logic [LEN_W-1:0]        i_inc;

    // configuration port
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[3] == REG_LENGTH) ?
        {{(DATA_W-LEN_W){1'b0}}, length_reg} : pattern_reg;

    // reference length in use, clamped to 1..REF_MAX
    always_comb begin
        m_used = length_reg;
        if (length_reg == '0) begin
            m_used = LEN_W'(1);
        end else if (length_reg > LEN_W'(REF_MAX)) begin
            m_used = LEN_W'(REF_MAX);
        end
    end

    // window set up for an arriving item
    assign s_fire   = s_valid && s_ready;
    assign c_new    = (bits_seen_reg != CNT_MAX) ? bits_seen_reg + 1'b1 : bits_seen_reg;
    assign full_win = c_new >= COUNT_BITS'(m_used);
    assign w_new    = full_win ? m_used : c_new[LEN_W-1:0];

    // shared xor/count step
    assign n_cur      = w_reg - i_reg;
    assign bit_mism   = recent_reg[age_reg] ^ pattern_reg[f_reg[AGE_W-1:0]];
    assign mism_inc   = mism_reg + LEN_W'(bit_mism);
    assign step_done  = (f_reg == n_cur - 1'b1);
    assign i_inc      = i_reg + 1'b1;
    assign last_score = (i_inc == cnt_reg);
    assign out_free   = !m_valid_reg || m_ready;
    assign score_val  = {1'b0, n_cur} - {mism_inc, 1'b0};
    assign lag_sum    = {1'b0, start_reg} + (COUNT_BITS+1)'(i_reg);
    assign lag_sat    = (lag_sum > LAG_MAX) ? LAG_MAX : lag_sum;

    // sequencer
    always_comb begin
        state_next     = state_reg;
        pattern_next   = pattern_reg;
        length_next    = length_reg;
        recent_next    = recent_reg;
        bits_seen_next = bits_seen_reg;
        w_next         = w_reg;
        cnt_next       = cnt_reg;
        i_next         = i_reg;
        f_next         = f_reg;
        age_next       = age_reg;
        mism_next      = mism_reg;
        last_next      = last_reg;
        start_next     = start_reg;
        m_valid_next   = m_valid_reg;
        m_lag_next     = m_lag_reg;
        m_score_next   = m_score_reg;
        m_last_next    = m_last_reg;

        // result taken downstream
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // register writes
        if (cfg_wr) begin
            case (paddr[3])
                REG_PATTERN: pattern_next = pwdata[PAT_W-1:0];
                REG_LENGTH:  length_next  = pwdata[LEN_W-1:0];
                default:     pattern_next = pattern_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    recent_next    = {recent_reg[PAT_W-2:0], s_data_bit};
                    bits_seen_next = c_new;
                    w_next         = w_new;
                    start_next     = c_new - COUNT_BITS'(w_new);
                    last_next      = s_last;
                    i_next         = '0;
                    f_next         = '0;
                    mism_next      = '0;
                    age_next       = AGE_W'(w_new - 1'b1);
                    if (s_last) begin
                        cnt_next   = w_new;
                        state_next = ST_RUN;
                    end else if (full_win) begin
                        cnt_next   = LEN_W'(1);
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (!step_done) begin
                    f_next    = f_reg + 1'b1;
                    age_next  = age_reg - 1'b1;
                    mism_next = mism_inc;
                end else if (out_free) begin
                    // hand the score to the output register
                    m_valid_next = 1'b1;
                    m_lag_next   = LAG_W'(lag_sat);
                    m_score_next = score_val;
                    m_last_next  = last_reg && last_score;
                    f_next       = '0;
                    mism_next    = '0;
                    i_next       = i_inc;
                    age_next     = AGE_W'(w_reg - 1'b1 - i_inc);
                    if (last_score) begin
                        state_next = ST_IDLE;
                        if (last_reg) begin
                            recent_next    = '0;
                            bits_seen_next = '0;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pattern_reg   <= '0;
            length_reg    <= LEN_RESET;
            recent_reg    <= '0;
            bits_seen_reg <= '0;
            m_valid_reg   <= 1'b0;
            i_reg         <= '0;
            cnt_reg       <= '0;
            w_reg         <= '0;
            f_reg         <= '0;
        end else begin
            state_reg     <= state_next;
            pattern_reg   <= pattern_next;
            length_reg    <= length_next;
            recent_reg    <= recent_next;
            bits_seen_reg <= bits_seen_next;
            m_valid_reg   <= m_valid_next;
            i_reg         <= i_next;
            cnt_reg       <= cnt_next;
            w_reg         <= w_next;
            f_reg         <= f_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        age_reg     <= age_next;
        mism_reg    <= mism_next;
        last_reg    <= last_next;
        start_reg   <= start_next;
        m_lag_reg   <= m_lag_next;
        m_score_reg <= m_score_next;
        m_last_reg  <= m_last_next;
    end

    // ports
    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_lag         = m_lag_reg;
    assign m_score       = m_score_reg;
    assign m_last_result = m_last_reg;

    // sequencer indexes stay inside the open window
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (i_reg < cnt_reg) && (f_reg < w_reg - i_reg))
        else $error("score index outside window");

    // final score of a stream clears the history
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && step_done && out_free && last_score && last_reg)
        |=> (bits_seen_reg == '0) && (recent_reg == '0) && m_last_result)
        else $error("stream state not cleared after final score");

    // scores stay within the reference span
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_score >= -8'sd64) && (m_score <= 8'sd64))
        else $error("score out of range");

endmodule
